// File: design/msws_pkg.sv
package msws_pkg;

    localparam int HALF_W  = 32;
    localparam int STATE_W = 2 * HALF_W;
    localparam int MOD_W   = 32;
    localparam int VALUE_W = 32;

    localparam logic [STATE_W-1:0] WEYL_STEP = 64'hb5ad_4ece_da1c_e2a9;

    // squarer retires one radix-4 digit of the multiplier per cycle
    localparam int SQR_STEPS = STATE_W / 2;
    localparam int SQR_CNT_W = $clog2(SQR_STEPS);

    // remainder unit retires one dividend bit per cycle
    localparam int REM_STEPS = STATE_W;
    localparam int REM_CNT_W = $clog2(REM_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } msws_unit_status_t;

endpackage

// File: design/msws_if.sv
interface msws_req_if import msws_pkg::*;;
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink (input valid, input modulus, output ready);
endinterface

interface msws_rsp_if import msws_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               bad_modulus;

    modport source (output valid, output value, output bad_modulus, input ready);
    modport sink (input valid, input value, input bad_modulus, output ready);
endinterface

// File: design/msws_sqr.sv
module msws_sqr import msws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [STATE_W-1:0] operand,
    output logic [STATE_W-1:0] product,
    output msws_unit_status_t  status
);

    logic [STATE_W-1:0]   mcand_reg;
    logic [STATE_W-1:0]   mcand3_reg;
    logic [STATE_W-1:0]   mplier_reg;
    logic [STATE_W-1:0]   acc_reg;
    logic [SQR_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [STATE_W-1:0]   addend;

    // radix-4 digit select: 0, x, 2x, 3x (all mod 2^64)
    always_comb
    begin
        case (mplier_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = mcand_reg;
            2'd2:    addend = {mcand_reg[STATE_W-2:0], 1'b0};
            default: addend = mcand3_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQR_CNT_W'(SQR_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= operand;
            mcand3_reg <= operand + {operand[STATE_W-2:0], 1'b0};
            mplier_reg <= operand;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + addend;
            mcand_reg  <= {mcand_reg[STATE_W-3:0], 2'b00};
            mcand3_reg <= {mcand3_reg[STATE_W-3:0], 2'b00};
            mplier_reg <= {2'b00, mplier_reg[STATE_W-1:2]};
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/msws_rem.sv
module msws_rem import msws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [STATE_W-1:0] dividend,
    input  logic [MOD_W-1:0]   divisor,
    output logic [MOD_W-1:0]   rem,
    output msws_unit_status_t  status
);

    logic [STATE_W-1:0]   dvd_reg;
    logic [MOD_W-1:0]     dvs_reg;
    logic [MOD_W-1:0]     rem_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_W:0]       trial;
    logic [MOD_W:0]       diff;
    logic [MOD_W-1:0]     rem_next;

    // restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[STATE_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
            rem_next = diff[MOD_W-1:0];
        else
            rem_next = trial[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[STATE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rem         = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/msws_random_range_core.sv
// a nonzero modulus runs through the 32-step radix-4 squarer and then the 64-step bit-serial
//   remainder unit before its result item; a zero modulus goes straight to the output state
// the two units run one after the other on the one item in flight, and no new item is taken
//   until that result is loaded; a result still waiting in the output register adds its wait
// a new item is taken while the previous result still waits in the output register
// reset (async, active low) clears the square state and weyl counter to zero,
//   the same as writing a seed of zero, and empties the output register
module msws_random_range_core import msws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [HALF_W-1:0] seed_data,
    msws_req_if.sink          req,
    msws_rsp_if.source        rsp
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQR   = 3'd1;
    localparam logic [2:0] ST_DIVGO = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    // generator state
    logic [STATE_W-1:0] square_reg;
    logic [STATE_W-1:0] weyl_reg;
    logic [STATE_W-1:0] mixed;

    // per-item registers
    logic [MOD_W-1:0]   mod_reg;
    logic               bad_reg;

    // output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_bad_reg;

    logic               req_take;
    logic               req_zero;
    logic               out_load;

    logic               sqr_start;
    logic [STATE_W-1:0] sqr_product;
    msws_unit_status_t  sqr_stat;

    logic               div_start;
    logic [MOD_W-1:0]   div_rem;
    msws_unit_status_t  div_stat;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign req_zero  = (req.modulus == '0);

    // squarer starts straight off the accepted item
    assign sqr_start = req_take && !req_zero;
    assign div_start = (state_reg == ST_DIVGO);

    // result moves into the output register once it is free or being drained
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    // square plus counter, then swap halves
    always_comb
    begin
        mixed = sqr_product + weyl_reg;
    end

    msws_sqr u_sqr
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqr_start),
        .operand (square_reg),
        .product (sqr_product),
        .status  (sqr_stat)
    );

    msws_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (square_reg),
        .divisor  (mod_reg),
        .rem      (div_rem),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    state_next = req_zero ? ST_OUT : ST_SQR;
            end
            ST_SQR:
            begin
                if (sqr_stat.done)
                    state_next = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            square_reg    <= '0;
            weyl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // seed write wins; the user must issue it only while nothing is in flight, the block does not enforce it
            if (seed_we)
            begin
                square_reg <= {seed_data, seed_data};
                weyl_reg   <= '0;
            end
            else
            begin
                if (sqr_start)
                    weyl_reg <= weyl_reg + WEYL_STEP;
                if ((state_reg == ST_SQR) && sqr_stat.done)
                    square_reg <= {mixed[HALF_W-1:0], mixed[STATE_W-1:HALF_W]};
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            mod_reg <= req.modulus;
            bad_reg <= req_zero;
        end
        if (out_load)
        begin
            out_value_reg <= bad_reg ? '0 : div_rem;
            out_bad_reg   <= bad_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.value       = out_value_reg;
    assign rsp.bad_modulus = out_bad_reg;

    // the two serial units never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sqr_stat.busy && div_stat.busy))
        else $error("squarer and remainder unit busy together");

    // a finished remainder is always below the item's modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_rem < mod_reg))
        else $error("remainder not below modulus");

    // squarer only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sqr_stat.done |-> (state_reg == ST_SQR))
        else $error("squarer done outside its phase");

    // a zero-modulus result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.bad_modulus) |-> (rsp.value == '0))
        else $error("error result with nonzero value");

    // remainder unit is launched only from its start phase
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_stat.busy) |-> ($past(state_reg) == ST_DIVGO))
        else $error("remainder unit started out of sequence");

endmodule
